/* sv/b2da_pkg.sv */
// shared types, constants and helpers for the binary to decimal text converter
package b2da_pkg;

  // format command codes
  localparam logic [1:0] CMD_U16 = 2'd0;
  localparam logic [1:0] CMD_S16 = 2'd1;
  localparam logic [1:0] CMD_U32 = 2'd2;

  // sizes
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned CHAR_W     = 7;

  // bit counts and digit counts per format
  localparam logic [5:0] BITS_WIDE    = 6'd32;
  localparam logic [5:0] BITS_NARROW  = 6'd16;
  localparam logic [3:0] DIGS_WIDE    = 4'd10;
  localparam logic [3:0] DIGS_NARROW  = 4'd5;

  // ascii codes
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // converter sequencer states
  typedef enum logic [1:0] {
    DB_IDLE,
    DB_SHIFT,
    DB_HOLD
  } db_state_t;

  // finished conversion handed from converter to character emitter
  typedef struct packed {
    logic             sign_en;
    logic             neg;
    logic             wide;
    logic [BCD_W-1:0] bcd;
  } conv_t;

  // add three to every digit of five or more
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    logic [DIGIT_W-1:0] d;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      if (d >= 4'd5) begin
        res[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
      end
    end
    return res;
  endfunction

  // every digit is a decimal digit
  function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* sv/b2da_if.sv */
// request channel interfaces for the converter input and the character output

interface b2da_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface b2da_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* sv/binary_to_decimal_ascii.sv */
// top level: binary number to fixed-width decimal ascii text
//
//   channel  dir  fields                       notes
//   in_chan  in   command[1:0], value[31:0]    one request per number
//   out_chan out  character[6:0], last         5, 6 or 10 requests per number
//
// conversion shifts in 16 bits for the 16-bit formats and 32 for the 32-bit
// format, one bit per cycle through the shift-and-add-three converter.
// the next number is taken only once the previous result has passed to the
// emitter, and converts while the previous text is being sent.
// reset is synchronous and active low; command code 3 is taken and dropped.
// a stalled output holds the converter result until the emitter is free.
module binary_to_decimal_ascii (
  input  logic         clk,
  input  logic         rst_n,
  b2da_in_if.sink      in_chan,
  b2da_out_if.source   out_chan
);

  logic            conv_valid;
  logic            conv_take;
  b2da_pkg::conv_t conv;

  // bit-serial converter
  b2da_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_command (in_chan.command),
    .in_value   (in_chan.value),
    .conv_valid (conv_valid),
    .conv_take  (conv_take),
    .conv_o     (conv)
  );

  // character emitter
  b2da_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .conv_valid    (conv_valid),
    .conv_take     (conv_take),
    .conv_i        (conv),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_character (out_chan.character),
    .out_last      (out_chan.last)
  );

endmodule

/* sv/b2da_dabble.sv */
// bit-serial shift-and-add-three binary to bcd converter
module b2da_dabble (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_value,
  output logic                conv_valid,
  input  logic                conv_take,
  output b2da_pkg::conv_t     conv_o
);

  b2da_pkg::db_state_t state_r, state_nxt;

  logic [b2da_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [b2da_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic                         sign_en_r, sign_en_nxt;
  logic                         neg_r, neg_nxt;
  logic                         wide_r, wide_nxt;

  logic                         start;
  logic [b2da_pkg::HALF_W-1:0]  low;
  logic [b2da_pkg::HALF_W-1:0]  mag;
  logic [b2da_pkg::BCD_W-1:0]   adj;

  assign start = in_valid && in_ready &&
                 (in_command == b2da_pkg::CMD_U16 || in_command == b2da_pkg::CMD_S16 ||
                  in_command == b2da_pkg::CMD_U32);
  assign low   = in_value[b2da_pkg::HALF_W-1:0];
  // magnitude of the signed half word; the most negative value wraps to 32768
  assign mag   = low[b2da_pkg::HALF_W-1] ? (~low + 16'd1) : low;
  assign adj   = b2da_pkg::bcd_adjust(bcd_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b2da_pkg::DB_IDLE: begin
        if (start) begin
          state_nxt = b2da_pkg::DB_SHIFT;
        end
      end
      b2da_pkg::DB_SHIFT: begin
        if (cnt_r == 6'd1) begin
          state_nxt = b2da_pkg::DB_HOLD;
        end
      end
      b2da_pkg::DB_HOLD: begin
        if (conv_take) begin
          state_nxt = b2da_pkg::DB_IDLE;
        end
      end
      default: state_nxt = b2da_pkg::DB_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    conv_valid = 1'b0;
    unique case (state_r)
      b2da_pkg::DB_IDLE:  in_ready   = 1'b1;
      b2da_pkg::DB_SHIFT: ;
      b2da_pkg::DB_HOLD:  conv_valid = 1'b1;
      default: ;
    endcase
  end

  assign conv_o.sign_en = sign_en_r;
  assign conv_o.neg     = neg_r;
  assign conv_o.wide    = wide_r;
  assign conv_o.bcd     = bcd_r;

  // datapath next values
  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    sign_en_nxt = sign_en_r;
    neg_nxt     = neg_r;
    wide_nxt    = wide_r;
    if (start) begin
      bcd_nxt     = '0;
      sign_en_nxt = (in_command == b2da_pkg::CMD_S16);
      neg_nxt     = (in_command == b2da_pkg::CMD_S16) && low[b2da_pkg::HALF_W-1];
      wide_nxt    = (in_command == b2da_pkg::CMD_U32);
      if (in_command == b2da_pkg::CMD_U32) begin
        bin_nxt = in_value;
        cnt_nxt = b2da_pkg::BITS_WIDE;
      end else if (in_command == b2da_pkg::CMD_S16) begin
        bin_nxt = {mag, {b2da_pkg::HALF_W{1'b0}}};
        cnt_nxt = b2da_pkg::BITS_NARROW;
      end else begin
        bin_nxt = {low, {b2da_pkg::HALF_W{1'b0}}};
        cnt_nxt = b2da_pkg::BITS_NARROW;
      end
    end else if (state_r == b2da_pkg::DB_SHIFT) begin
      // adjust digits, then shift one binary bit into the bcd word
      bcd_nxt = {adj[b2da_pkg::BCD_W-2:0], bin_r[b2da_pkg::VALUE_W-1]};
      bin_nxt = {bin_r[b2da_pkg::VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2da_pkg::DB_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    sign_en_r <= sign_en_nxt;
    neg_r     <= neg_nxt;
    wide_r    <= wide_nxt;
  end

  // shifting ends with the bit count spent
  a_hold_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b2da_pkg::DB_HOLD |-> cnt_r == 6'd0)
    else $error("conversion finished with bits left");

  // digits stay decimal while shifting
  a_bcd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b2da_pkg::DB_SHIFT |-> b2da_pkg::bcd_ok(bcd_r))
    else $error("bcd digit out of range");

  // a finished result stays until taken
  a_hold_stays: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b2da_pkg::DB_HOLD && !conv_take |=> state_r == b2da_pkg::DB_HOLD && $stable(bcd_r))
    else $error("conversion result lost");

endmodule

/* sv/b2da_emit.sv */
// serializes a bcd result into ascii characters, one character per request, sign first for the signed format
module b2da_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              conv_valid,
  output logic                              conv_take,
  input  b2da_pkg::conv_t                   conv_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_last
);

  logic [b2da_pkg::BCD_W-1:0]  sh_r, sh_nxt;
  logic [3:0]                  left_r, left_nxt;
  logic                        sign_pend_r, sign_pend_nxt;
  logic                        neg_r, neg_nxt;
  logic                        valid_r, valid_nxt;
  logic [b2da_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                        last_r, last_nxt;

  logic active;
  logic advance;
  logic [b2da_pkg::DIGIT_W-1:0] top_digit;

  assign active    = (left_r != 4'd0) || sign_pend_r;
  assign conv_take = conv_valid && !active;
  assign advance   = active && (!valid_r || out_ready);
  assign top_digit = sh_r[b2da_pkg::BCD_W-1 -: b2da_pkg::DIGIT_W];

  // character sequencing and output register
  always_comb begin
    sh_nxt        = sh_r;
    left_nxt      = left_r;
    sign_pend_nxt = sign_pend_r;
    neg_nxt       = neg_r;
    valid_nxt     = valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (conv_take) begin
      // narrow results sit in the low five digits; move them to the top
      sh_nxt        = conv_i.wide ? conv_i.bcd
                                  : {conv_i.bcd[b2da_pkg::BCD_W/2-1:0],
                                     {(b2da_pkg::BCD_W/2){1'b0}}};
      left_nxt      = conv_i.wide ? b2da_pkg::DIGS_WIDE : b2da_pkg::DIGS_NARROW;
      sign_pend_nxt = conv_i.sign_en;
      neg_nxt       = conv_i.neg;
    end else if (advance) begin
      valid_nxt = 1'b1;
      if (sign_pend_r) begin
        char_nxt      = neg_r ? b2da_pkg::CHAR_MINUS : b2da_pkg::CHAR_PLUS;
        last_nxt      = 1'b0;
        sign_pend_nxt = 1'b0;
      end else begin
        char_nxt = b2da_pkg::DIGIT_BASE | {3'b000, top_digit};
        last_nxt = (left_r == 4'd1);
        sh_nxt   = {sh_r[b2da_pkg::BCD_W-b2da_pkg::DIGIT_W-1:0],
                    {b2da_pkg::DIGIT_W{1'b0}}};
        left_nxt = left_r - 4'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      sign_pend_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      sign_pend_r <= sign_pend_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  // the final digit carries the last flag and ends the run
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !sign_pend_r && left_r == 4'd1 |=> valid_r && last_r && left_r == 4'd0)
    else $error("last flag missing at the end of a run");

  // a taken result starts a run of characters
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    conv_take |=> left_r == b2da_pkg::DIGS_WIDE || left_r == b2da_pkg::DIGS_NARROW)
    else $error("taken result did not start a run");

endmodule

/* test/tb_binary_to_decimal_ascii.sv */
// testbench for the binary to decimal ascii text converter
module tb_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  // command code that the block takes and drops
  localparam logic [1:0] CMD_NONE = 2'd3;

  // one expected character of a text run
  typedef struct {
    logic [b2da_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  // expected characters of every accepted number, oldest first
  class text_scoreboard;
    text_char_t pending[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // work out the text of an accepted number and queue its characters
    function void note_number(logic [1:0] cmd, logic [31:0] val);
      logic [31:0]                 mag;
      logic [31:0]                 rem;
      int                          ndig;
      logic [b2da_pkg::CHAR_W-1:0] digs[b2da_pkg::NUM_DIGITS];
      text_char_t                  tc;
      case (cmd)
        b2da_pkg::CMD_U16: begin
          mag  = {16'd0, val[15:0]};
          ndig = 5;
        end
        b2da_pkg::CMD_S16: begin
          // magnitude at full width, so -32768 stays correct
          tc.last = 1'b0;
          if (val[15]) begin
            tc.character = b2da_pkg::CHAR_MINUS;
            mag = 32'h0001_0000 - {16'd0, val[15:0]};
          end else begin
            tc.character = b2da_pkg::CHAR_PLUS;
            mag = {16'd0, val[15:0]};
          end
          pending.push_back(tc);
          ndig = 5;
        end
        b2da_pkg::CMD_U32: begin
          mag  = val;
          ndig = 10;
        end
        default: begin
          return;
        end
      endcase
      // zero-padded digits, least significant worked out first
      for (int k = ndig - 1; k >= 0; k--) begin
        rem     = mag % 10;
        digs[k] = b2da_pkg::DIGIT_BASE + rem[b2da_pkg::CHAR_W-1:0];
        mag     = mag / 10;
      end
      for (int k = 0; k < ndig; k++) begin
        tc.character = digs[k];
        tc.last      = (k == ndig - 1);
        pending.push_back(tc);
      end
    endfunction

    // compare an accepted character with the oldest expectation
    function void check_char(logic [b2da_pkg::CHAR_W-1:0] ch, logic lst);
      text_char_t want;
      if (pending.size() == 0) begin
        $error("unexpected character 0x%02h last %0b", ch, lst);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (ch !== want.character) begin
        $error("character: expected 0x%02h, got 0x%02h", want.character, ch);
        mismatches++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  text_scoreboard board;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // character receiver: check accepted requests, stall at random
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      board.check_char(out_if.character, out_if.last);
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // present one number and hold it until accepted; valid stays high after
  task automatic send_number(input logic [1:0] cmd, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    do @(posedge clk); while (!in_if.ready);
    board.note_number(cmd, val);
  endtask

  // stop sending until every expected character has come
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // random numbers with a bias toward the interesting corners
  task automatic send_random_run(input int count);
    int          sent;
    int          pick;
    logic [1:0]  cmd;
    logic [31:0] val;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(19);
      if (pick < 6) begin
        cmd = b2da_pkg::CMD_U16;
      end else if (pick < 12) begin
        cmd = b2da_pkg::CMD_S16;
      end else if (pick < 19) begin
        cmd = b2da_pkg::CMD_U32;
      end else begin
        cmd = CMD_NONE;
      end
      case ($urandom_range(7))
        0, 1, 2, 3: val = $urandom();
        4: val = $urandom_range(99);
        5: val = {16'($urandom()), 16'h7FFE + 16'($urandom_range(3))};
        6: val = 32'hFFFF_FFFF - $urandom_range(9);
        default: val = {16'($urandom()), 16'hFFFF - 16'($urandom_range(9))};
      endcase
      send_number(cmd, val);
      if (cmd != CMD_NONE) begin
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    board         = new();
    send_idle_pct = 36;
    recv_idle_pct = 50;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.command = b2da_pkg::CMD_U16;
    in_if.value   = 32'd0;
    out_if.ready  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every format, dropped command, special cases
    send_number(b2da_pkg::CMD_U16, 32'd0);
    send_number(b2da_pkg::CMD_U16, 32'h0000_FFFF);
    send_number(b2da_pkg::CMD_U16, 32'hFFFF_0000);
    send_number(b2da_pkg::CMD_U16, 32'h0001_3039);
    send_number(b2da_pkg::CMD_S16, 32'd0);
    send_number(b2da_pkg::CMD_S16, 32'h0000_7FFF);
    send_number(b2da_pkg::CMD_S16, 32'h0000_8000);
    send_number(b2da_pkg::CMD_S16, 32'hFFFF_FFFF);
    send_number(b2da_pkg::CMD_S16, 32'h0000_0001);
    send_number(b2da_pkg::CMD_S16, 32'hABCD_8000);
    send_number(CMD_NONE, 32'hFFFF_FFFF);
    send_number(b2da_pkg::CMD_U32, 32'd0);
    send_number(b2da_pkg::CMD_U32, 32'hFFFF_FFFF);
    send_number(b2da_pkg::CMD_U32, 32'd1_000_000_000);
    send_number(b2da_pkg::CMD_U32, 32'd999_999_999);
    send_number(b2da_pkg::CMD_U32, 32'h8000_0000);
    send_number(CMD_NONE, 32'd0);
    send_number(b2da_pkg::CMD_U16, 32'd9);
    send_number(b2da_pkg::CMD_S16, 32'h0000_FFF6);
    send_number(b2da_pkg::CMD_U32, 32'd4_294_967_294);
    wait_drained();

    // random: sender idles less than receiver
    send_random_run(155);
    wait_drained();

    // random: receiver idles less than sender
    send_idle_pct = 50;
    recv_idle_pct = 36;
    send_random_run(155);
    wait_drained();

    // random: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_run(155);
    wait_drained();

    // let any stray characters surface
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("binary_to_decimal_ascii test failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/b2da_pkg.sv
sv/b2da_if.sv
sv/b2da_dabble.sv
sv/b2da_emit.sv
sv/binary_to_decimal_ascii.sv
test/tb_binary_to_decimal_ascii.sv
